FILE: rtl/tmn_pkg.sv
// Package: shared types and constants of the ticket mutex node.
`timescale 1ns / 1ps
package tmn_pkg;

	localparam int ID_W     = 8;
	localparam int TICKET_W = 16;
	localparam int STEP_W   = 7;

	localparam logic [STEP_W-1:0]   STEP_MIN   = 7'd1;
	localparam logic [STEP_W-1:0]   STEP_MAX   = 7'd100;
	localparam logic [TICKET_W-1:0] TICKET_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_LREQ  = 2'd0,
		CMD_PREQ  = 2'd1,
		CMD_PCONF = 2'd2,
		CMD_EXIT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_BCAST   = 2'd1,
		ACT_CONFIRM = 2'd2,
		ACT_GRANT   = 2'd3
	} action_t;

	// decoded event handed from the front to the back
	typedef struct packed {
		cmd_t                cmd;
		logic [ID_W-1:0]     origin_id;
		logic [TICKET_W-1:0] peer_ticket;
		logic [STEP_W-1:0]   step;
	} op_t;

endpackage

FILE: rtl/tmn_if.sv
// Interfaces: event input channel and result output channel.
`timescale 1ns / 1ps
interface tmn_evt_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic [tmn_pkg::ID_W-1:0]      origin_id;
	logic [tmn_pkg::TICKET_W-1:0]  peer_ticket;
	logic [tmn_pkg::STEP_W-1:0]    rand_step;

	modport source (output valid, cmd, origin_id, peer_ticket, rand_step, input ready);
	modport sink (input valid, cmd, origin_id, peer_ticket, rand_step, output ready);
endinterface

interface tmn_res_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [tmn_pkg::ID_W-1:0]      dest_id;
	logic [tmn_pkg::TICKET_W-1:0]  ticket_out;
	logic                          last;

	modport source (output valid, action, dest_id, ticket_out, last, input ready);
	modport sink (input valid, action, dest_id, ticket_out, last, output ready);
endinterface

FILE: rtl/tmn_front.sv
// Front: accepts events, decodes them and holds them in a two-entry queue.
`timescale 1ns / 1ps
module tmn_front (
	input  logic             clk,
	input  logic             arst_n,
	tmn_evt_if.sink          evt,
	output logic             op_valid,
	input  logic             op_ready,
	output tmn_pkg::op_t     op
);

	tmn_pkg::op_t       q_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	tmn_pkg::op_t       dec;
	logic               push;
	logic               pop;

	always_comb begin
		dec.cmd         = tmn_pkg::cmd_t'(evt.cmd);
		dec.origin_id   = evt.origin_id;
		dec.peer_ticket = evt.peer_ticket;
		if (evt.rand_step < tmn_pkg::STEP_MIN) begin
			dec.step = tmn_pkg::STEP_MIN;
		end else if (evt.rand_step > tmn_pkg::STEP_MAX) begin
			dec.step = tmn_pkg::STEP_MAX;
		end else begin
			dec.step = evt.rand_step;
		end
	end

	assign evt.ready = (cnt_q != 2'd2);
	assign op_valid  = (cnt_q != 2'd0);
	assign op        = q_q[rd_ptr_q];
	assign push      = evt.valid && evt.ready;
	assign pop       = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/tmn_back.sv
// Back: protocol state, deferred-peer memory and the result register.
`timescale 1ns / 1ps
module tmn_back #(
	parameter int NODES = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tmn_pkg::ID_W-1:0] cfg_wdata,
	input  logic                     op_valid,
	output logic                     op_ready,
	input  tmn_pkg::op_t             op,
	tmn_res_if.source                res
);

	localparam int PEERS = NODES - 1;
	localparam int CNT_W = $clog2(NODES);
	localparam int IDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;
	localparam logic [CNT_W-1:0] PEERS_C = CNT_W'(PEERS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SEND
	} state_t;

	state_t                         state_q;
	logic [tmn_pkg::ID_W-1:0]       own_id_q;
	logic [tmn_pkg::TICKET_W-1:0]   own_ticket_q;
	logic [tmn_pkg::TICKET_W-1:0]   max_seen_q;
	logic                           requesting_q;
	logic [CNT_W-1:0]               confirm_cnt_q;
	logic [CNT_W-1:0]               defer_cnt_q;
	logic [IDX_W-1:0]               rd_idx_q;

	logic [tmn_pkg::ID_W-1:0]       defer_mem_q [PEERS];
	logic [tmn_pkg::ID_W-1:0]       rd_data_q;

	logic                           out_valid_q;
	tmn_pkg::action_t               out_action_q;
	logic [tmn_pkg::ID_W-1:0]       out_dest_q;
	logic [tmn_pkg::TICKET_W-1:0]   out_ticket_q;
	logic                           out_last_q;

	logic                           can_load;
	logic                           take;
	logic [tmn_pkg::TICKET_W:0]     sum;
	logic [tmn_pkg::TICKET_W-1:0]   new_ticket;
	logic                           peer_wins;
	logic                           defer_we;
	logic                           send_last;

	assign can_load = !out_valid_q || res.ready;
	assign op_ready = (state_q == ST_IDLE) && can_load;
	assign take     = op_valid && op_ready;

	assign sum        = {1'b0, max_seen_q} + (tmn_pkg::TICKET_W + 1)'(op.step);
	assign new_ticket = sum[tmn_pkg::TICKET_W] ? tmn_pkg::TICKET_MAX
	                                           : sum[tmn_pkg::TICKET_W-1:0];
	assign peer_wins  = !requesting_q || (op.peer_ticket < own_ticket_q) ||
	                    ((op.peer_ticket == own_ticket_q) && (op.origin_id < own_id_q));
	assign defer_we   = take && (op.cmd == tmn_pkg::CMD_PREQ) && !peer_wins &&
	                    (defer_cnt_q < PEERS_C);
	assign send_last  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == defer_cnt_q);

	assign res.valid      = out_valid_q;
	assign res.action     = out_action_q;
	assign res.dest_id    = out_dest_q;
	assign res.ticket_out = out_ticket_q;
	assign res.last       = out_last_q;

	always_ff @(posedge clk) begin
		if (defer_we) begin
			defer_mem_q[defer_cnt_q[IDX_W-1:0]] <= op.origin_id;
		end
		rd_data_q <= defer_mem_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			own_id_q      <= '0;
			own_ticket_q  <= '0;
			max_seen_q    <= '0;
			requesting_q  <= 1'b0;
			confirm_cnt_q <= '0;
			defer_cnt_q   <= '0;
			rd_idx_q      <= '0;
			out_valid_q   <= 1'b0;
			out_action_q  <= tmn_pkg::ACT_NONE;
			out_dest_q    <= '0;
			out_ticket_q  <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				own_id_q <= cfg_wdata;
			end
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (op.cmd)
							tmn_pkg::CMD_LREQ: begin
								own_ticket_q  <= new_ticket;
								requesting_q  <= 1'b1;
								confirm_cnt_q <= '0;
								out_valid_q   <= 1'b1;
								out_action_q  <= tmn_pkg::ACT_BCAST;
								out_dest_q    <= '0;
								out_ticket_q  <= new_ticket;
								out_last_q    <= 1'b1;
							end
							tmn_pkg::CMD_PREQ: begin
								if (op.peer_ticket > max_seen_q) begin
									max_seen_q <= op.peer_ticket;
								end
								if (peer_wins) begin
									out_valid_q  <= 1'b1;
									out_action_q <= tmn_pkg::ACT_CONFIRM;
									out_dest_q   <= op.origin_id;
									out_ticket_q <= '0;
									out_last_q   <= 1'b1;
								end else if (defer_we) begin
									defer_cnt_q <= defer_cnt_q + CNT_W'(1);
								end
							end
							tmn_pkg::CMD_PCONF: begin
								if (confirm_cnt_q < PEERS_C) begin
									confirm_cnt_q <= confirm_cnt_q + CNT_W'(1);
									if ((confirm_cnt_q + CNT_W'(1)) == PEERS_C) begin
										out_valid_q  <= 1'b1;
										out_action_q <= tmn_pkg::ACT_GRANT;
										out_dest_q   <= '0;
										out_ticket_q <= '0;
										out_last_q   <= 1'b1;
									end
								end
							end
							default: begin
								requesting_q <= 1'b0;
								if (defer_cnt_q != '0) begin
									rd_idx_q <= '0;
									state_q  <= ST_FETCH;
								end
							end
						endcase
					end
				end
				// memory read of rd_idx_q lands in rd_data_q at this edge
				ST_FETCH: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (can_load) begin
						out_valid_q  <= 1'b1;
						out_action_q <= tmn_pkg::ACT_CONFIRM;
						out_dest_q   <= rd_data_q;
						out_ticket_q <= '0;
						out_last_q   <= send_last;
						if (send_last) begin
							defer_cnt_q <= '0;
							state_q     <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + IDX_W'(1);
							state_q  <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/ticket_mutex_node.sv
// Top level: ticket-based mutual-exclusion node, front queue plus protocol back end.
//
// Usage:
//   evt carries one protocol event per transaction: cmd, origin_id, peer_ticket,
//   rand_step. res carries the results: action, dest_id, ticket_out, last; the
//   final result of an event has last set. Events that cause no result (deferred
//   peer request, non-granting confirm, exit with an empty queue) return nothing.
//   cfg_we/cfg_wdata write own_id; write it only while the node is idle.
// Dataflow:
//   An event is registered in a two-entry queue, then loaded into the result
//   register once the back end is idle and that register free. Single-result
//   events sustain one per cycle while res.ready is high and the queue primed.
//   A local exit with k deferred peers sends k confirms via deferred-id reads.
// Reset: arst_n clears the protocol state, the queue and own_id; the
//   deferred-id memory is not cleared since only entries below the count are read.
// Stall: a result waits in the output register while res.ready is low; the
//   front queue keeps taking events until both entries are full.
`timescale 1ns / 1ps
module ticket_mutex_node #(
	parameter int NODES = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tmn_pkg::ID_W-1:0] cfg_wdata,
	tmn_evt_if.sink                  evt,
	tmn_res_if.source                res
);

	logic          op_valid;
	logic          op_ready;
	tmn_pkg::op_t  op;

	tmn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	tmn_back #(
		.NODES (NODES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.res       (res)
	);

	// a full queue always has something to offer the back end
	a_full_has_op: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> op_valid)
		else $error("queue full with no pending op");

	// the back end never takes an op while a result is stalled
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && op_ready) |-> !(res.valid && !res.ready))
		else $error("op taken while result stalled");

	// grant and broadcast carry no destination
	a_grant_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.action == tmn_pkg::ACT_GRANT)) |->
		(res.dest_id == '0) && (res.ticket_out == '0) && res.last)
		else $error("grant result with stray fields");

	// a broadcast is the only result of its event
	a_single_results_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.action == tmn_pkg::ACT_BCAST)) |->
		(res.dest_id == '0) && res.last)
		else $error("broadcast result malformed");

endmodule
